/* src/sliding_window_max_mono_deque_core_macros.svh */
// assertion macros shared by the sliding window maximum rtl
// no dependencies; included by files that carry assertions
`ifndef SLIDING_WINDOW_MAX_MONO_DEQUE_CORE_MACROS_SVH
`define SLIDING_WINDOW_MAX_MONO_DEQUE_CORE_MACROS_SVH

// condition holds at every clock outside reset
`define SWMAX_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SWMAX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SWMAX_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* src/swmax_pkg.sv */
// types and constants of the sliding window maximum block
// no dependencies
`default_nettype none

package swmax_pkg;

    localparam int unsigned SAMPLE_W  = 32;
    localparam int unsigned CFG_W     = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CFG_W-1:0]           t_cfg;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic fill_inc;
        logic rd_head;
        logic rd_tail;
        logic retire;
        logic pop;
        logic insert;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic occ_zero;
        logic occ_full;
        logic rd_less;
        logic out_busy;
    } t_sts;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CHECK   = 8'b0000_0010,
        S_RETIRE  = 8'b0000_0100,
        S_POP_RD  = 8'b0000_1000,
        S_POP     = 8'b0001_0000,
        S_INSERT  = 8'b0010_0000,
        S_EMIT_RD = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

endpackage

`default_nettype wire

/* src/swmax_in_if.sv */
// input channel: one sample word with restart flag
// depends on swmax_pkg
`default_nettype none

interface swmax_in_if;
    logic               valid;
    logic               ready;
    swmax_pkg::t_sample sample;
    logic               restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

/* src/swmax_out_if.sv */
// output channel: one window maximum word
// depends on swmax_pkg
`default_nettype none

interface swmax_out_if;
    logic               valid;
    logic               ready;
    swmax_pkg::t_sample window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

/* src/swmax_ctrl.sv */
// controller fsm of the sliding window maximum block
// depends on swmax_pkg
`default_nettype none

module swmax_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire swmax_pkg::t_sts i_sts,
    output swmax_pkg::t_cmd      o_cmd
);

    swmax_pkg::t_state r_state;
    swmax_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swmax_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == swmax_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            swmax_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = swmax_pkg::S_CHECK;
                end
            end
            swmax_pkg::S_CHECK: begin
                priority if (!i_sts.full) begin
                    o_cmd.fill_inc = 1'b1;
                    n_state        = swmax_pkg::S_POP_RD;
                end else if (i_sts.occ_zero) begin
                    n_state = swmax_pkg::S_POP_RD;
                end else begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = swmax_pkg::S_RETIRE;
                end
            end
            swmax_pkg::S_RETIRE: begin
                o_cmd.retire = 1'b1;
                n_state      = swmax_pkg::S_POP_RD;
            end
            swmax_pkg::S_POP_RD: begin
                if (i_sts.occ_zero) begin
                    n_state = swmax_pkg::S_INSERT;
                end else begin
                    o_cmd.rd_tail = 1'b1;
                    n_state       = swmax_pkg::S_POP;
                end
            end
            swmax_pkg::S_POP: begin
                if (i_sts.rd_less) begin
                    o_cmd.pop = 1'b1;
                    n_state   = swmax_pkg::S_POP_RD;
                end else begin
                    n_state = swmax_pkg::S_INSERT;
                end
            end
            swmax_pkg::S_INSERT: begin
                o_cmd.insert = !i_sts.occ_full;
                n_state      = swmax_pkg::S_EMIT_RD;
            end
            swmax_pkg::S_EMIT_RD: begin
                if (i_sts.full && !i_sts.occ_zero) begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = swmax_pkg::S_EMIT;
                end else begin
                    n_state = swmax_pkg::S_IDLE;
                end
            end
            swmax_pkg::S_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = swmax_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swmax_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/swmax_dp.sv */
// datapath: deque memory, head and occupancy, fill count, output register
// depends on swmax_pkg and the assertion macro header
`default_nettype none
`include "sliding_window_max_mono_deque_core_macros.svh"

module swmax_dp #(
    parameter int unsigned WINDOW_MAX = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire swmax_pkg::t_cfg    i_cfg_wdata,
    input  wire swmax_pkg::t_sample i_sample,
    input  wire logic               i_restart,
    input  wire swmax_pkg::t_cmd    i_cmd,
    output swmax_pkg::t_sts         o_sts,
    output logic                    o_out_valid,
    output swmax_pkg::t_sample      o_out_value,
    input  wire logic               i_out_ready
);

    localparam int unsigned AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned OW  = $clog2(WINDOW_MAX + 1);
    localparam int unsigned SW  = OW + 1;
    localparam int unsigned SKW = AW;
    localparam int unsigned CW  = (OW > swmax_pkg::CFG_W) ? OW : swmax_pkg::CFG_W;

    swmax_pkg::t_sample mem_value [WINDOW_MAX];
    logic [SKW-1:0]     mem_skip  [WINDOW_MAX];

    swmax_pkg::t_cfg    r_ws;
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      n_head;
    logic [OW-1:0]      r_occ;
    logic [OW-1:0]      n_occ;
    logic [OW-1:0]      r_fill;
    logic [OW-1:0]      n_fill;
    logic               r_out_valid;
    swmax_pkg::t_sample r_out_value;
    swmax_pkg::t_sample r_sample;
    logic [SKW-1:0]     r_merged;
    swmax_pkg::t_sample r_rd_value;
    logic [SKW-1:0]     r_rd_skip;

    logic [SW-1:0]      tail_sum;
    logic [SW-1:0]      ins_sum;
    logic [AW-1:0]      tail_addr;
    logic [AW-1:0]      ins_addr;
    logic [AW-1:0]      head_inc;
    logic [AW-1:0]      rd_addr;
    logic [CW-1:0]      ws_ext;
    logic [CW-1:0]      k_eff;
    logic               skip_we;
    logic [SKW-1:0]     skip_wdata;
    logic [AW-1:0]      skip_waddr;

    // circular addressing
    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_occ) - SW'(1);
        ins_sum  = SW'(r_head) + SW'(r_occ);
        tail_addr = (tail_sum >= SW'(WINDOW_MAX)) ?
                    AW'(tail_sum - SW'(WINDOW_MAX)) : AW'(tail_sum);
        ins_addr  = (ins_sum >= SW'(WINDOW_MAX)) ?
                    AW'(ins_sum - SW'(WINDOW_MAX)) : AW'(ins_sum);
        head_inc  = (r_head == AW'(WINDOW_MAX - 1)) ? AW'(0) : r_head + AW'(1);
        rd_addr   = i_cmd.rd_tail ? tail_addr : r_head;
    end

    // effective window length
    always_comb begin
        ws_ext = CW'(r_ws);
        if (ws_ext == CW'(0)) begin
            k_eff = CW'(1);
        end else if (ws_ext > CW'(WINDOW_MAX)) begin
            k_eff = CW'(WINDOW_MAX);
        end else begin
            k_eff = ws_ext;
        end
    end

    assign o_sts.full     = (CW'(r_fill) >= k_eff);
    assign o_sts.occ_zero = (r_occ == OW'(0));
    assign o_sts.occ_full = (r_occ >= OW'(WINDOW_MAX));
    assign o_sts.rd_less  = (r_rd_value < r_sample);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        n_head = r_head;
        n_occ  = r_occ;
        n_fill = r_fill;
        if (i_cmd.accept && i_restart) begin
            n_head = AW'(0);
            n_occ  = OW'(0);
            n_fill = OW'(0);
        end
        if (i_cmd.fill_inc) begin
            n_fill = r_fill + OW'(1);
        end
        if (i_cmd.retire && (r_rd_skip == SKW'(0))) begin
            n_head = head_inc;
            n_occ  = r_occ - OW'(1);
        end
        if (i_cmd.pop) begin
            n_occ = r_occ - OW'(1);
        end
        if (i_cmd.insert) begin
            n_occ = r_occ + OW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= swmax_pkg::CFG_RESET;
            r_head      <= AW'(0);
            r_occ       <= OW'(0);
            r_fill      <= OW'(0);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ws <= i_cfg_wdata;
            end
            r_head <= n_head;
            r_occ  <= n_occ;
            r_fill <= n_fill;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_merged <= SKW'(0);
        end else if (i_cmd.pop) begin
            r_merged <= r_merged + r_rd_skip + SKW'(1);
        end
        if (i_cmd.load_out) begin
            r_out_value <= r_rd_value;
        end
    end

    // deque memory, one write and one registered read per cycle
    always_comb begin
        skip_we    = i_cmd.insert || (i_cmd.retire && (r_rd_skip != SKW'(0)));
        skip_wdata = i_cmd.insert ? r_merged : r_rd_skip - SKW'(1);
        skip_waddr = i_cmd.insert ? ins_addr : r_head;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            mem_value[ins_addr] <= r_sample;
        end
        if (skip_we) begin
            mem_skip[skip_waddr] <= skip_wdata;
        end
        if (i_cmd.rd_head || i_cmd.rd_tail) begin
            r_rd_value <= mem_value[rd_addr];
            r_rd_skip  <= mem_skip[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;

    `SWMAX_ASSERT_ALWAYS(a_occ_bound, i_clk, i_rst_n, r_occ <= OW'(WINDOW_MAX), "occupancy over depth")
    `SWMAX_ASSERT_ALWAYS(a_head_bound, i_clk, i_rst_n, SW'(r_head) < SW'(WINDOW_MAX), "head out of range")
    `SWMAX_ASSERT_SAME(a_load_free, i_clk, i_rst_n, i_cmd.load_out, !(r_out_valid && !i_out_ready), "result overwritten")
    `SWMAX_ASSERT_NEXT(a_restart_clr, i_clk, i_rst_n, i_cmd.accept && i_restart, r_occ == OW'(0) && r_fill == OW'(0), "restart left state")

endmodule

`default_nettype wire

/* src/sliding_window_max_mono_deque_core.sv */
// sliding window maximum over a signed sample stream, monotonic deque
// top level: joins swmax_ctrl and swmax_dp; depends on swmax_pkg and the interfaces
//
// i_smp carries one sample word with a restart flag; o_res carries one
// window maximum word. both use valid/ready, a word moves when both are high.
// i_cfg_we with i_cfg_wdata writes the window length (0 acts as 1, values
// above WINDOW_MAX act as WINDOW_MAX); write it only while the block is idle.
// one sample is worked at a time. from acceptance a sample passes a check
// state, a retire step once the window is full, a tail read and a compare
// for each queue entry that the new sample removes and for one that stays,
// the insert, and once the window is full a head read and the result load;
// the next sample can be taken in the cycle after the result is loaded. the
// deque memory is walked one entry at a time, a read and a compare in turn.
// samples before the window is full give no result.
// reset clears the queue, the fill count and the output valid flag and sets
// the window length to 3; no clearing pass is needed.
// while o_res is stalled the result register holds, the next sample is
// still accepted and worked up to its own result, which then waits.
`default_nettype none

module sliding_window_max_mono_deque_core #(
    parameter int unsigned WINDOW_MAX = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire swmax_pkg::t_cfg i_cfg_wdata,
    swmax_in_if.sink             i_smp,
    swmax_out_if.source          o_res
);

    swmax_pkg::t_cmd cmd;
    swmax_pkg::t_sts sts;

    swmax_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    swmax_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_smp.sample),
        .i_restart   (i_smp.restart),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_res.valid),
        .o_out_value (o_res.window_max),
        .i_out_ready (o_res.ready)
    );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for sliding_window_max_mono_deque_core
// a scoreboard class predicts every window maximum from the accepted sample words
// depends on swmax_pkg, swmax_in_if, swmax_out_if and sliding_window_max_mono_deque_core
`default_nettype none

module tb_top;

    localparam int unsigned DEQ_DEPTH   = 64;
    localparam int unsigned EXP_DEPTH   = 16;
    localparam int unsigned SETTLE      = 160;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    class swmax_scoreboard;
        swmax_pkg::t_sample deq_value [DEQ_DEPTH];
        bit [5:0]           deq_skip  [DEQ_DEPTH];
        int unsigned        deq_head;
        int unsigned        deq_count;
        int unsigned        fill_count;
        swmax_pkg::t_cfg    window_len;
        swmax_pkg::t_sample exp_buf [EXP_DEPTH];
        int unsigned        exp_rd;
        int unsigned        exp_wr;
        int unsigned        exp_count;
        int                 error_count;

        function new();
            deq_head    = 0;
            deq_count   = 0;
            fill_count  = 0;
            window_len  = swmax_pkg::CFG_RESET;
            exp_rd      = 0;
            exp_wr      = 0;
            exp_count   = 0;
            error_count = 0;
        endfunction

        function void write_window(swmax_pkg::t_cfg v);
            window_len = v;
        endfunction

        function void note_sample(swmax_pkg::t_sample s, logic restart);
            int unsigned k;
            int unsigned merged;
            int unsigned tail;
            k = window_len;
            if (k == 0) k = 1;
            if (k > DEQ_DEPTH) k = DEQ_DEPTH;
            if (restart) begin
                deq_head   = 0;
                deq_count  = 0;
                fill_count = 0;
            end
            // oldest sample leaves once the window is full
            if (fill_count >= k) begin
                if (deq_count != 0) begin
                    if (deq_skip[deq_head] != 0) begin
                        deq_skip[deq_head] = deq_skip[deq_head] - 6'd1;
                    end else begin
                        deq_head  = (deq_head + 1) % DEQ_DEPTH;
                        deq_count = deq_count - 1;
                    end
                end
            end else begin
                fill_count = fill_count + 1;
            end
            merged = 0;
            while (deq_count > 0) begin
                tail = (deq_head + deq_count - 1) % DEQ_DEPTH;
                if (deq_value[tail] >= s) break;
                merged    = merged + deq_skip[tail] + 1;
                deq_count = deq_count - 1;
            end
            if (deq_count < DEQ_DEPTH) begin
                tail            = (deq_head + deq_count) % DEQ_DEPTH;
                deq_value[tail] = s;
                deq_skip[tail]  = 6'(merged);
                deq_count       = deq_count + 1;
            end
            if (fill_count >= k && deq_count != 0) begin
                exp_buf[exp_wr] = deq_value[deq_head];
                exp_wr          = (exp_wr + 1) % EXP_DEPTH;
                exp_count       = exp_count + 1;
            end
        endfunction

        function void check_max(swmax_pkg::t_sample got);
            swmax_pkg::t_sample want;
            if (exp_count == 0) begin
                $display("%0t: window max %0d arrived with none expected", $time, got);
                error_count++;
            end else begin
                want      = exp_buf[exp_rd];
                exp_rd    = (exp_rd + 1) % EXP_DEPTH;
                exp_count = exp_count - 1;
                if (got !== want) begin
                    $display("%0t: window max expected %0d, actual %0d", $time, want, got);
                    error_count++;
                end
            end
        endfunction

        function int pending();
            return exp_count;
        endfunction
    endclass

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we;
    swmax_pkg::t_cfg i_cfg_wdata;
    int unsigned     cycle_count = 0;

    swmax_in_if  smp ();
    swmax_out_if res ();

    swmax_scoreboard sb = new();

    swmax_pkg::t_sample last_smp = '0;
    int      smp_mode = 0;
    int      mode_left = 0;
    bit      steady_src = 1'b0;

    sliding_window_max_mono_deque_core #(
        .WINDOW_MAX (DEQ_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_smp       (smp),
        .o_res       (res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (smp.valid && smp.ready) sb.note_sample(smp.sample, smp.restart);
            if (res.valid && res.ready) sb.check_max(res.window_max);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // bursts of random, narrow-range, rising, falling or extreme words
    function automatic swmax_pkg::t_sample next_sample();
        if (mode_left == 0) begin
            smp_mode  = $urandom_range(0, 4);
            mode_left = $urandom_range(8, 30);
        end
        mode_left--;
        case (smp_mode)
            0: last_smp = $urandom;
            1: last_smp = $signed($urandom_range(0, 8)) - 4;
            2: last_smp = last_smp + $urandom_range(0, 3);
            3: last_smp = last_smp - $urandom_range(0, 3);
            default: begin
                case ($urandom_range(0, 3))
                    0: last_smp = 32'sh8000_0000;
                    1: last_smp = 32'sh7fff_ffff;
                    2: last_smp = '0;
                    default: last_smp = -1;
                endcase
            end
        endcase
        return last_smp;
    endfunction

    task automatic send_word(input swmax_pkg::t_sample s, input logic r);
        int gap;
        gap = steady_src ? 0 : pick_gap();
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid   <= 1'b1;
        smp.sample  <= s;
        smp.restart <= r;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(input swmax_pkg::t_cfg v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.write_window(v);
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_words();
        send_word(32'sh7fff_ffff, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(0, 1'b0);
        send_word(-1, 1'b0);
        send_word(-1, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word(2, 1'b0);
        send_word(3, 1'b0);
        send_word(3, 1'b0);
        send_word(2, 1'b0);
        send_word(1, 1'b0);
        send_word(5, 1'b1);
        send_word(6, 1'b0);
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh7fff_ffff, 1'b0);
        send_word(32'sh7fff_fffe, 1'b0);
        send_word(32'sh8000_0001, 1'b0);
        send_word(0, 1'b0);
    endtask

    function automatic swmax_pkg::t_cfg phase_window(int p);
        case (p)
            0:  return 7'd1;
            1:  return 7'd0;
            2:  return 7'd2;
            3:  return 7'd5;
            4:  return 7'd64;
            5:  return 7'd7;
            6:  return 7'd127;
            7:  return 7'd3;
            8:  return 7'd65;
            9:  return swmax_pkg::t_cfg'($urandom_range(1, 40));
            10: return 7'd12;
            default: return swmax_pkg::t_cfg'($urandom_range(0, 127));
        endcase
    endfunction

    initial begin
        res.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            res.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 200)) @(posedge i_clk);
            else repeat ($urandom_range(1, 8)) @(posedge i_clk);
            begin
                int gap;
                gap = pick_gap();
                if (gap > 0) begin
                    res.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        swmax_pkg::t_cfg w;
        int unsigned     eff;
        int              n;
        smp.valid   <= 1'b0;
        smp.sample  <= '0;
        smp.restart <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= swmax_pkg::CFG_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_words();

        for (int p = 0; p < 12; p++) begin
            w = phase_window(p);
            write_window(w);
            eff = (w == 0) ? 1 : (w > DEQ_DEPTH) ? DEQ_DEPTH : w;
            n = (eff >= 32) ? 90 : 40;
            steady_src = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n; i++)
                send_word(next_sample(), $urandom_range(0, 59) == 0);
        end

        drain();
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
